// ===== hw/rtl/csrr_pkg.sv =====
// ----------------------------------------------------------------------------
// csrr_pkg
// Shared types, constants and slot arithmetic for the card stack unit.
// ----------------------------------------------------------------------------
package csrr_pkg;

  localparam int unsigned DEPTH   = 256;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CARD_W  = 32;
  localparam int unsigned VALUE_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_ROTATE  = 2'd2,
    OP_REVERSE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_SHORT = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    status_e              status;
    logic [CARD_W-1:0]    card_out;
    logic [COUNT_W-1:0]   card_count;
  } result_t;

  // k slots toward the bottom; the ring wraps naturally at a power-of-two depth
  function automatic logic [ADDR_W-1:0] slot_down(input logic [ADDR_W-1:0] slot,
                                                  input logic [ADDR_W-1:0] k,
                                                  input logic              flipped);
    logic [ADDR_W-1:0] res;
    if (flipped) begin
      res = slot - k;
    end else begin
      res = slot + k;
    end
    return res;
  endfunction

  // one slot toward the top
  function automatic logic [ADDR_W-1:0] slot_up(input logic [ADDR_W-1:0] slot,
                                                input logic              flipped);
    logic [ADDR_W-1:0] res;
    if (flipped) begin
      res = slot + 1'b1;
    end else begin
      res = slot - 1'b1;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/csrr_ram.sv =====
// ----------------------------------------------------------------------------
// csrr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csrr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/csrr_core.sv =====
// ----------------------------------------------------------------------------
// csrr_core
// Ring pointer, count and direction flag, with the sequencer that drives
// the card memory. Pop and rotate pass through a second state that uses the read data.
// ----------------------------------------------------------------------------
module csrr_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                req_valid_i,
  output logic                                req_ready_o,
  input  csrr_pkg::op_e                       op_i,
  input  logic [csrr_pkg::CARD_W-1:0]         card_i,
  input  logic                                out_free_i,
  output logic                                res_valid_o,
  output csrr_pkg::result_t                   res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_RD,
    S_ROT_WR
  } state_e;

  state_e                              state_q, state_d;
  logic [csrr_pkg::ADDR_W-1:0]         top_q, top_d;
  logic [csrr_pkg::COUNT_W-1:0]        count_q, count_d;
  logic                                flip_q, flip_d;
  logic [csrr_pkg::ADDR_W-1:0]         below_q, below_d;

  logic                                ram_we, ram_re;
  logic [csrr_pkg::ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [csrr_pkg::VALUE_W-1:0]        ram_wdata, ram_rdata;
  logic                                accept;

  assign req_ready_o = (state_q == S_IDLE) && out_free_i;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d   = state_q;
    top_d     = top_q;
    count_d   = count_q;
    flip_d    = flip_q;
    below_d   = below_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = top_q;
    ram_raddr = top_q;
    ram_wdata = card_i[csrr_pkg::VALUE_W-1:0];
    res_valid_o         = 1'b0;
    res_o.status        = csrr_pkg::STAT_DONE;
    res_o.card_out      = '0;
    res_o.card_count    = count_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            csrr_pkg::OP_PUSH: begin
              res_valid_o = 1'b1;
              if (count_q == csrr_pkg::COUNT_W'(csrr_pkg::DEPTH)) begin
                res_o.status = csrr_pkg::STAT_FULL;
              end else begin
                top_d     = csrr_pkg::slot_up(top_q, flip_q);
                ram_we    = 1'b1;
                ram_waddr = top_d;
                count_d   = count_q + 1'b1;
                res_o.card_count = count_d;
              end
            end
            csrr_pkg::OP_POP: begin
              if (count_q == '0) begin
                res_valid_o  = 1'b1;
                res_o.status = csrr_pkg::STAT_EMPTY;
              end else begin
                ram_re  = 1'b1;
                top_d   = csrr_pkg::slot_down(top_q, csrr_pkg::ADDR_W'(1), flip_q);
                count_d = count_q - 1'b1;
                state_d = S_POP_RD;
              end
            end
            csrr_pkg::OP_ROTATE: begin
              res_valid_o = 1'b1;
              if (count_q < csrr_pkg::COUNT_W'(2)) begin
                res_o.status = csrr_pkg::STAT_SHORT;
              end else begin
                // a full ring puts the bottom slot on the top slot itself
                ram_re  = 1'b1;
                below_d = csrr_pkg::slot_down(top_q, count_q[csrr_pkg::ADDR_W-1:0], flip_q);
                top_d   = csrr_pkg::slot_down(top_q, csrr_pkg::ADDR_W'(1), flip_q);
                state_d = S_ROT_WR;
              end
            end
            csrr_pkg::OP_REVERSE: begin
              res_valid_o = 1'b1;
              if (count_q != '0) begin
                top_d = csrr_pkg::slot_down(top_q,
                                            csrr_pkg::ADDR_W'(count_q - 1'b1), flip_q);
              end
              flip_d = ~flip_q;
            end
            default: begin
              res_valid_o = 1'b0;
            end
          endcase
        end
      end
      S_POP_RD: begin
        res_valid_o    = 1'b1;
        res_o.card_out = csrr_pkg::CARD_W'(ram_rdata);
        state_d        = S_IDLE;
      end
      S_ROT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = below_q;
        ram_wdata = ram_rdata;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      top_q   <= '0;
      count_q <= '0;
      flip_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      count_q <= count_d;
      flip_q  <= flip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    below_q <= below_d;
  end

  csrr_ram #(
    .WIDTH (csrr_pkg::VALUE_W),
    .DEPTH (csrr_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== hw/rtl/card_stack_rotate_reverse_unit.sv =====
// Push, reverse and every failed request: result registered on accept, next request
//   taken in the following cycle when the output stage is free.
// Pop and rotate: a second state (S_POP_RD, S_ROT_WR) for the read of the card RAM
//   takes no request; rotate registers its result on accept, pop after S_POP_RD.
// Reset clears top pointer, count and direction flag at once; the card RAM is
//   not cleared and is only read at slots that hold cards.
// ----------------------------------------------------------------------------
// card_stack_rotate_reverse_unit
// Bounded card deck in a ring RAM with push, pop, rotate and reverse.
// ----------------------------------------------------------------------------
module card_stack_rotate_reverse_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] card_in
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] card_out, [40:32] card_count, zero above
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic              out_free;
  logic              res_valid;
  csrr_pkg::result_t res;
  csrr_pkg::result_t out_q;
  logic              out_valid_q, out_valid_d;

  assign out_free = !out_valid_q || m_axis_tready;

  csrr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .op_i        (csrr_pkg::op_e'(s_axis_tuser)),
    .card_i      (s_axis_tdata),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {7'b0, out_q.card_count, out_q.card_out};

`ifndef NO_ASSERTIONS
  // a new result never lands on one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free)
    else $error("result overwrites pending output");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.status == csrr_pkg::STAT_FULL)
      |-> res.card_count == csrr_pkg::COUNT_W'(csrr_pkg::DEPTH))
    else $error("full status with count below depth");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.status == csrr_pkg::STAT_EMPTY) |-> res.card_count == '0)
    else $error("empty status with cards held");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.status != csrr_pkg::STAT_DONE) |-> res.card_out == '0)
    else $error("failed request returns a card");

  // while a pop is in S_POP_RD, no request is taken
  a_two_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == csrr_pkg::OP_POP && !res_valid)
      |=> !s_axis_tready)
    else $error("request taken during memory read");
`endif

endmodule
